// ----- rtl/ssdp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ssdp_pkg;

  // Pixel coordinate handling: only the low COORD_BITS bits of a position are used.
  localparam int COORD_BITS = 12;
  localparam int PIX_W      = 12;
  localparam int GRAD_W     = 16;
  localparam int USE_BITS   = (COORD_BITS < PIX_W) ? COORD_BITS : PIX_W;
  localparam int POS_W      = USE_BITS + 4;

  // Arithmetic widths, each large enough to hold its value exactly.
  localparam int CTR_W      = 17;
  localparam int TRIG_W     = 16;
  localparam int SCL_W      = 16;
  localparam int XY_W       = ((POS_W > CTR_W) ? POS_W : CTR_W) + 2;
  localparam int UV_W       = TRIG_W + XY_W + 1;
  localparam int QP_W       = GRAD_W + UV_W + 1;
  localparam int QL_W       = QP_W / 2;
  localparam int QH_W       = QP_W - QL_W;
  localparam int ROT_SHIFT  = 28;
  localparam int SCL_SHIFT  = 14;
  localparam int VAL_W      = 32;

  // Queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_FIT_T   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIT_R   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIT_S   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COS     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SIN     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 3'd7;

  // Bit positions in the plane mask, in output order.
  localparam int NPLANES = 4;
  localparam int PL_TX   = 0;
  localparam int PL_TY   = 1;
  localparam int PL_ROT  = 2;
  localparam int PL_SCL  = 3;

  typedef struct packed {
    logic [PIX_W-1:0]         pixel_x;
    logic [PIX_W-1:0]         pixel_y;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
  } in_t;

  typedef struct packed {
    logic [1:0]              plane;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } out_t;

  typedef struct packed {
    logic                     fit_translation;
    logic                     fit_rotation;
    logic                     fit_scale;
    logic signed [CTR_W-1:0]  center_x;
    logic signed [CTR_W-1:0]  center_y;
    logic signed [TRIG_W-1:0] cos_angle;
    logic signed [TRIG_W-1:0] sin_angle;
    logic [SCL_W-1:0]         scale_factor;
  } cfg_t;

  // One classified pixel as it waits in the queue.
  typedef struct packed {
    logic signed [XY_W-1:0]   x;
    logic signed [XY_W-1:0]   y;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [NPLANES-1:0]       mask;
  } entry_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (VAL_W - 1)) - 64'sd1;
    lo = -(64'sd1 <<< (VAL_W - 1));
    if (v > hi) begin
      return hi[VAL_W-1:0];
    end else if (v < lo) begin
      return lo[VAL_W-1:0];
    end
    return v[VAL_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ssdp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Takes pixels in, forms the centered coordinates and the mask of planes to emit.
module ssdp_front (
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire ssdp_pkg::in_t   in_data,
  input  wire ssdp_pkg::cfg_t  cfg,
  input  wire                  q_full,
  output logic                 q_push,
  output ssdp_pkg::entry_t     q_entry
);

  logic [ssdp_pkg::POS_W-1:0] pos_x;
  logic [ssdp_pkg::POS_W-1:0] pos_y;

  always_comb begin
    pos_x = {in_data.pixel_x[ssdp_pkg::USE_BITS-1:0], 4'b0000};
    pos_y = {in_data.pixel_y[ssdp_pkg::USE_BITS-1:0], 4'b0000};

    q_entry.x = ssdp_pkg::XY_W'($signed({1'b0, pos_x})) - ssdp_pkg::XY_W'(cfg.center_x);
    q_entry.y = ssdp_pkg::XY_W'($signed({1'b0, pos_y})) - ssdp_pkg::XY_W'(cfg.center_y);
    q_entry.gx = in_data.grad_x;
    q_entry.gy = in_data.grad_y;

    q_entry.mask = '0;
    q_entry.mask[ssdp_pkg::PL_TX]  = cfg.fit_translation;
    q_entry.mask[ssdp_pkg::PL_TY]  = cfg.fit_translation;
    q_entry.mask[ssdp_pkg::PL_ROT] = cfg.fit_rotation;
    q_entry.mask[ssdp_pkg::PL_SCL] = cfg.fit_scale;
  end

  // A pixel with nothing to fit is accepted and dropped here.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && (q_entry.mask != '0);

endmodule

`default_nettype wire

// ----- rtl/ssdp_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Short queue of classified pixels between the front and back parts.
module ssdp_fifo (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     push,
  input  wire ssdp_pkg::entry_t   push_entry,
  output logic                    full,
  input  wire                     pop,
  output logic                    not_empty,
  output ssdp_pkg::entry_t        pop_entry
);

  ssdp_pkg::entry_t             mem_r [ssdp_pkg::QUEUE_DEPTH];
  logic [ssdp_pkg::QA_W-1:0]    wr_ptr_r;
  logic [ssdp_pkg::QA_W-1:0]    wr_ptr_nxt;
  logic [ssdp_pkg::QA_W-1:0]    rd_ptr_r;
  logic [ssdp_pkg::QA_W-1:0]    rd_ptr_nxt;
  logic [ssdp_pkg::QA_W:0]      count_r;
  logic [ssdp_pkg::QA_W:0]      count_nxt;

  assign full      = (count_r == (ssdp_pkg::QA_W + 1)'(ssdp_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ssdp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Arithmetic pipeline (four stages) followed by a result sequencer.
module ssdp_back (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire ssdp_pkg::cfg_t     cfg,
  input  wire                     q_valid,
  input  wire ssdp_pkg::entry_t   q_entry,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire                     out_stall,
  output ssdp_pkg::out_t          out_data
);

  localparam int PH_W  = ssdp_pkg::QH_W + ssdp_pkg::SCL_W + 1;
  localparam int PL_W  = ssdp_pkg::SCL_W + ssdp_pkg::QL_W;
  localparam int W_W   = PL_W + 1;
  localparam int RS_W  = PH_W + 1;
  localparam int PR_W  = ssdp_pkg::QP_W + 1;
  localparam int M1_W  = ssdp_pkg::TRIG_W + ssdp_pkg::XY_W;
  localparam int M2_W  = ssdp_pkg::GRAD_W + ssdp_pkg::UV_W;

  localparam logic [W_W-1:0] ROT_RND = W_W'(64'd1 << (ssdp_pkg::ROT_SHIFT - 1));
  localparam logic signed [PR_W-1:0] SCL_RND =
    PR_W'(64'sd1 <<< (ssdp_pkg::SCL_SHIFT - 1));

  typedef struct packed {
    logic signed [ssdp_pkg::GRAD_W-1:0] gx;
    logic signed [ssdp_pkg::GRAD_W-1:0] gy;
    logic [ssdp_pkg::NPLANES-1:0]       mask;
  } carry_t;

  // Pipeline control.
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic adv;

  // Stage payloads.
  carry_t s1_c_r, s2_c_r, s3_c_r, s4_c_r;
  logic signed [ssdp_pkg::UV_W-1:0]  u_r, u_nxt, v_r, v_nxt;
  logic signed [ssdp_pkg::QP_W-1:0]  q_r, q_nxt, p_r, p_nxt;
  logic signed [PH_W-1:0]            ph_r, ph_nxt;
  logic [PL_W-1:0]                   pl_r, pl_nxt;
  logic signed [ssdp_pkg::VAL_W-1:0] sc3_r, sc3_nxt, sc4_r;
  logic signed [ssdp_pkg::VAL_W-1:0] rot_r, rot_nxt;

  // Stage intermediates.
  logic signed [M1_W-1:0] m_cx, m_sy, m_sx, m_cy;
  logic signed [M2_W-1:0] m_yu, m_xv, m_xu, m_yv;
  logic signed [ssdp_pkg::QH_W-1:0] qh;
  logic [ssdp_pkg::QL_W-1:0]        ql;
  logic signed [ssdp_pkg::SCL_W:0]  s_ext;
  logic signed [PR_W-1:0]           pr;
  logic signed [PR_W-1:0]           sc_full;
  logic [W_W-1:0]                   w_sum;
  logic [ssdp_pkg::SCL_W:0]         w_hi;
  logic signed [RS_W-1:0]           rsum;
  logic signed [RS_W-1:0]           rot_full;

  // Sequencer.
  logic                               hold_v_r, hold_v_nxt;
  logic [ssdp_pkg::NPLANES-1:0]       mask_r, mask_nxt;
  logic [1:0]                         plane_r, plane_nxt;
  logic signed [ssdp_pkg::GRAD_W-1:0] hgx_r, hgy_r;
  logic signed [ssdp_pkg::VAL_W-1:0]  hrot_r, hsc_r;
  logic [ssdp_pkg::NPLANES-1:0]       rest;
  logic signed [ssdp_pkg::VAL_W-1:0]  sel_val;
  logic                               emit, emit_last, take;
  logic                               out_valid_r, out_valid_nxt;
  ssdp_pkg::out_t                     out_data_r;

  // Stage 1: rotate the centered coordinates.
  always_comb begin
    m_cx  = cfg.cos_angle * q_entry.x;
    m_sy  = cfg.sin_angle * q_entry.y;
    m_sx  = cfg.sin_angle * q_entry.x;
    m_cy  = cfg.cos_angle * q_entry.y;
    u_nxt = ssdp_pkg::UV_W'(m_cx) - ssdp_pkg::UV_W'(m_sy);
    v_nxt = ssdp_pkg::UV_W'(m_sx) + ssdp_pkg::UV_W'(m_cy);
  end

  // Stage 2: weight by the gradients.
  always_comb begin
    m_yu  = s1_c_r.gy * u_r;
    m_xv  = s1_c_r.gx * v_r;
    m_xu  = s1_c_r.gx * u_r;
    m_yv  = s1_c_r.gy * v_r;
    q_nxt = ssdp_pkg::QP_W'(m_yu) - ssdp_pkg::QP_W'(m_xv);
    p_nxt = ssdp_pkg::QP_W'(m_xu) + ssdp_pkg::QP_W'(m_yv);
  end

  // Stage 3: scale times Q as two partial products; round the scale plane.
  always_comb begin
    qh      = $signed(q_r[ssdp_pkg::QP_W-1:ssdp_pkg::QL_W]);
    ql      = q_r[ssdp_pkg::QL_W-1:0];
    s_ext   = $signed({1'b0, cfg.scale_factor});
    ph_nxt  = s_ext * qh;
    pl_nxt  = cfg.scale_factor * ql;
    pr      = PR_W'(p_r) + SCL_RND;
    sc_full = pr >>> ssdp_pkg::SCL_SHIFT;
    sc3_nxt = ssdp_pkg::sat32(64'(sc_full));
  end

  // Stage 4: combine the partial products, round and saturate the rotation plane.
  always_comb begin
    w_sum    = W_W'(pl_r) + ROT_RND;
    w_hi     = w_sum[W_W-1:ssdp_pkg::QL_W];
    rsum     = RS_W'(ph_r) + RS_W'($signed({1'b0, w_hi}));
    rot_full = rsum >>> (ssdp_pkg::ROT_SHIFT - ssdp_pkg::QL_W);
    rot_nxt  = ssdp_pkg::sat32(64'(rot_full));
  end

  // Sequencer: emits the planes of the held pixel one per transaction.
  always_comb begin
    rest    = mask_r;
    sel_val = hsc_r;
    if (mask_r[ssdp_pkg::PL_TX]) begin
      sel_val = ssdp_pkg::VAL_W'(hgx_r);
      rest[ssdp_pkg::PL_TX] = 1'b0;
    end else if (mask_r[ssdp_pkg::PL_TY]) begin
      sel_val = ssdp_pkg::VAL_W'(hgy_r);
      rest[ssdp_pkg::PL_TY] = 1'b0;
    end else if (mask_r[ssdp_pkg::PL_ROT]) begin
      sel_val = hrot_r;
      rest[ssdp_pkg::PL_ROT] = 1'b0;
    end else begin
      rest[ssdp_pkg::PL_SCL] = 1'b0;
    end

    emit      = hold_v_r && (!out_valid_r || !out_stall);
    emit_last = emit && (rest == '0);
    take      = s4_v_r && (!hold_v_r || emit_last);
    adv       = !s4_v_r || take;
    q_pop     = q_valid && adv;

    hold_v_nxt = hold_v_r;
    mask_nxt   = mask_r;
    plane_nxt  = plane_r;
    if (take) begin
      hold_v_nxt = 1'b1;
      mask_nxt   = s4_c_r.mask;
      plane_nxt  = '0;
    end else if (emit) begin
      hold_v_nxt = !emit_last;
      mask_nxt   = rest;
      plane_nxt  = plane_r + 1'b1;
    end

    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      hold_v_r    <= 1'b0;
      mask_r      <= '0;
      plane_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        s1_v_r <= q_valid;
        s2_v_r <= s1_v_r;
        s3_v_r <= s2_v_r;
        s4_v_r <= s3_v_r;
      end
      hold_v_r    <= hold_v_nxt;
      mask_r      <= mask_nxt;
      plane_r     <= plane_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u_r    <= u_nxt;
      v_r    <= v_nxt;
      s1_c_r <= '{gx: q_entry.gx, gy: q_entry.gy, mask: q_entry.mask};
      q_r    <= q_nxt;
      p_r    <= p_nxt;
      s2_c_r <= s1_c_r;
      ph_r   <= ph_nxt;
      pl_r   <= pl_nxt;
      sc3_r  <= sc3_nxt;
      s3_c_r <= s2_c_r;
      rot_r  <= rot_nxt;
      sc4_r  <= sc3_r;
      s4_c_r <= s3_c_r;
    end
    if (take) begin
      hgx_r  <= s4_c_r.gx;
      hgy_r  <= s4_c_r.gy;
      hrot_r <= rot_r;
      hsc_r  <= sc4_r;
    end
    if (emit) begin
      out_data_r.plane <= plane_r;
      out_data_r.value <= sel_val;
      out_data_r.last  <= (rest == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/similarity_steepest_descent_pixel.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Steepest-descent values of a rotation-scale-translation warp, one pixel per transaction.
// The input channel (in_valid, in_stall, in_data) takes a pixel position and its x and y
// gradients. The result channel (out_valid, out_stall, out_data) returns one transaction
// per adjustable parameter, in the order translation x, translation y, rotation, scale,
// with a dense plane number and last set on the final result of the pixel.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes one
// register per transaction; cfg_ready is always high. Write it only while the block is idle.
// Throughput: a pixel occupies the single result channel for one transaction per fitted plane;
// a pixel with nothing to fit is taken at the input and produces no results. The result
// channel, one result a cycle while out_stall is low, sets the rate.
// A four-entry queue separates the front part from the arithmetic pipeline, so inputs keep
// flowing while results wait. When the receiver stalls, the held result stays put, the
// pipeline freezes, the queue fills and then in_stall rises.
// Reset (synchronous, rst_n low) empties the queue and pipeline and restores the
// registers to: all planes fitted, center zero, cosine 1.0, sine zero, scale 1.0.
module similarity_steepest_descent_pixel (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire ssdp_pkg::in_t                   in_data,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output ssdp_pkg::out_t                       out_data,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire [ssdp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [ssdp_pkg::CFG_DATA_W-1:0]       cfg_data
);

  ssdp_pkg::cfg_t   cfg_r;
  ssdp_pkg::cfg_t   cfg_nxt;
  ssdp_pkg::entry_t push_entry;
  ssdp_pkg::entry_t pop_entry;
  logic             q_full;
  logic             q_push;
  logic             q_pop;
  logic             q_not_empty;

  assign cfg_ready = 1'b1;

  // Register file; unknown indexes are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        ssdp_pkg::REG_FIT_T: begin
          cfg_nxt.fit_translation = cfg_data[0];
        end
        ssdp_pkg::REG_FIT_R: begin
          cfg_nxt.fit_rotation = cfg_data[0];
        end
        ssdp_pkg::REG_FIT_S: begin
          cfg_nxt.fit_scale = cfg_data[0];
        end
        ssdp_pkg::REG_CENTER_X: begin
          cfg_nxt.center_x = $signed(cfg_data[ssdp_pkg::CTR_W-1:0]);
        end
        ssdp_pkg::REG_CENTER_Y: begin
          cfg_nxt.center_y = $signed(cfg_data[ssdp_pkg::CTR_W-1:0]);
        end
        ssdp_pkg::REG_COS: begin
          cfg_nxt.cos_angle = $signed(cfg_data[ssdp_pkg::TRIG_W-1:0]);
        end
        ssdp_pkg::REG_SIN: begin
          cfg_nxt.sin_angle = $signed(cfg_data[ssdp_pkg::TRIG_W-1:0]);
        end
        ssdp_pkg::REG_SCALE: begin
          cfg_nxt.scale_factor = cfg_data[ssdp_pkg::SCL_W-1:0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fit_translation <= 1'b1;
      cfg_r.fit_rotation    <= 1'b1;
      cfg_r.fit_scale       <= 1'b1;
      cfg_r.center_x        <= '0;
      cfg_r.center_y        <= '0;
      cfg_r.cos_angle       <= ssdp_pkg::TRIG_W'(16384);
      cfg_r.sin_angle       <= '0;
      cfg_r.scale_factor    <= ssdp_pkg::SCL_W'(16384);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ssdp_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  ssdp_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .pop_entry  (pop_entry)
  );

  ssdp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_not_empty),
    .q_entry   (pop_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- tb/sv/similarity_steepest_descent_pixel_test.sv -----
`timescale 1ns / 1ps

module similarity_steepest_descent_pixel_test;
  import ssdp_pkg::*;

  // The run is ended by force if it has not finished after this many clock cycles.
  localparam int LIMIT_CYCLES = 200000;
  // Cycles to let pass after the last result before registers are rewritten. A pixel
  // with nothing to fit gives no result; the block drops it at the input.
  localparam int SETTLE_CYCLES = 16;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Pixels waiting to be driven, and the results still owed by the block, oldest first.
  in_t pixels_to_send[$];
  out_t planes_due[$];

  // The register contents that the block holds, as far as the predictor knows.
  cfg_t active_cfg;

  // Percent chance per cycle that the sender idles or the receiver stalls.
  int send_idle_pct;
  int recv_stall_pct;

  int mismatch_count;
  int cycle_count;

  similarity_steepest_descent_pixel dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Saturates a wide signed value to the 32-bit result range.
  function automatic logic signed [VAL_W-1:0] clamp_word(input logic signed [127:0] v);
    if (v > 128'sh7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < -128'sh8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[VAL_W-1:0];
  endfunction

  // Works out the steepest-descent values of one pixel under the current registers and
  // queues them in output order. All arithmetic is done at 128 bits, which holds every
  // intermediate product exactly, even for out-of-range cosine, sine and scale patterns.
  function automatic void predict_planes(input in_t p);
    logic signed [127:0] gx, gy, xx, yy, cx, cy, ca, sa, sc;
    logic signed [127:0] u, v, q, pp, rot, scl;
    int col, row;
    logic [1:0] plane;
    out_t r;
    out_t batch[$];
    gx = 128'(p.grad_x);
    gy = 128'(p.grad_y);
    col = p.pixel_x & ((1 << COORD_BITS) - 1);
    row = p.pixel_y & ((1 << COORD_BITS) - 1);
    cx = 128'(active_cfg.center_x);
    cy = 128'(active_cfg.center_y);
    ca = 128'(active_cfg.cos_angle);
    sa = 128'(active_cfg.sin_angle);
    sc = $signed(128'(active_cfg.scale_factor));
    // Position relative to the center, in 1/16 pixel.
    xx = 128'(col);
    xx = xx * 16 - cx;
    yy = 128'(row);
    yy = yy * 16 - cy;
    // Rotated position in 2^-18 pixel units.
    u = ca * xx - sa * yy;
    v = sa * xx + ca * yy;
    plane = '0;
    r.last = 1'b0;
    if (active_cfg.fit_translation) begin
      r.plane = plane;
      r.value = gx[VAL_W-1:0];
      batch.push_back(r);
      plane++;
      r.plane = plane;
      r.value = gy[VAL_W-1:0];
      batch.push_back(r);
      plane++;
    end
    if (active_cfg.fit_rotation) begin
      // Round to nearest with halves going up: add half an LSB, then floor.
      q = gy * u - gx * v;
      rot = (sc * q + (128'sd1 <<< (ROT_SHIFT - 1))) >>> ROT_SHIFT;
      r.plane = plane;
      r.value = clamp_word(rot);
      batch.push_back(r);
      plane++;
    end
    if (active_cfg.fit_scale) begin
      pp = gx * u + gy * v;
      scl = (pp + (128'sd1 <<< (SCL_SHIFT - 1))) >>> SCL_SHIFT;
      r.plane = plane;
      r.value = clamp_word(scl);
      batch.push_back(r);
    end
    if (batch.size() > 0) begin
      batch[batch.size() - 1].last = 1'b1;
    end
    foreach (batch[i]) begin
      planes_due.push_back(batch[i]);
    end
  endfunction

  function automatic in_t make_pixel(input int x, input int y, input int gx, input int gy);
    in_t p;
    p.pixel_x = PIX_W'(x);
    p.pixel_y = PIX_W'(y);
    p.grad_x = GRAD_W'(gx);
    p.grad_y = GRAD_W'(gy);
    return p;
  endfunction

  // Positions cover the whole image. Gradients mostly span the full signed range, with
  // a share of small ones so that results do not always saturate.
  function automatic in_t random_pixel();
    in_t p;
    p.pixel_x = PIX_W'($urandom_range(0, 4095));
    p.pixel_y = PIX_W'($urandom_range(0, 4095));
    if ($urandom_range(0, 3) == 0) begin
      p.grad_x = GRAD_W'($urandom_range(0, 511) - 256);
      p.grad_y = GRAD_W'($urandom_range(0, 511) - 256);
    end else begin
      p.grad_x = 16'($urandom);
      p.grad_y = 16'($urandom);
    end
    return p;
  endfunction

  function automatic cfg_t settings(input int t, input int r, input int s, input int cx,
                                    input int cy, input int cosv, input int sinv,
                                    input int scale);
    cfg_t c;
    c.fit_translation = 1'(t);
    c.fit_rotation = 1'(r);
    c.fit_scale = 1'(s);
    c.center_x = CTR_W'(cx);
    c.center_y = CTR_W'(cy);
    c.cos_angle = TRIG_W'(cosv);
    c.sin_angle = TRIG_W'(sinv);
    c.scale_factor = SCL_W'(scale);
    return c;
  endfunction

  // Mostly plausible geometry; one setting in four uses raw bit patterns instead, so that
  // every register bit gets exercised, out-of-range trig values included.
  function automatic cfg_t random_settings();
    cfg_t c;
    c.fit_translation = 1'($urandom_range(0, 1));
    c.fit_rotation = 1'($urandom_range(0, 1));
    c.fit_scale = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) begin
      c.center_x = 17'($urandom);
      c.center_y = 17'($urandom);
      c.cos_angle = 16'($urandom);
      c.sin_angle = 16'($urandom);
      c.scale_factor = 16'($urandom);
    end else begin
      c.center_x = CTR_W'($urandom_range(0, 131071) - 65536);
      c.center_y = CTR_W'($urandom_range(0, 131071) - 65536);
      c.cos_angle = TRIG_W'($urandom_range(0, 32768) - 16384);
      c.sin_angle = TRIG_W'($urandom_range(0, 32768) - 16384);
      c.scale_factor = SCL_W'($urandom_range(8192, 32768));
    end
    return c;
  endfunction

  // One register write transaction; cfg_valid stays up until cfg_ready is seen with it.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_settings(input cfg_t c);
    write_register(REG_FIT_T, CFG_DATA_W'(c.fit_translation));
    write_register(REG_FIT_R, CFG_DATA_W'(c.fit_rotation));
    write_register(REG_FIT_S, CFG_DATA_W'(c.fit_scale));
    write_register(REG_CENTER_X, CFG_DATA_W'(c.center_x));
    write_register(REG_CENTER_Y, CFG_DATA_W'(c.center_y));
    write_register(REG_COS, CFG_DATA_W'(c.cos_angle));
    write_register(REG_SIN, CFG_DATA_W'(c.sin_angle));
    write_register(REG_SCALE, CFG_DATA_W'(c.scale_factor));
    active_cfg = c;
  endtask

  // Holds back until every queued pixel has been taken and every owed result has come,
  // then lets SETTLE_CYCLES pass. Conditions are
  // sampled on the falling edge, where nothing is changing.
  task automatic wait_until_idle();
    do @(negedge clk); while (pixels_to_send.size() != 0 || in_valid || planes_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Starts a new group of pixels: the block is drained, the registers are rewritten and
  // the idling pattern is chosen. Pixels are queued afterwards, on a falling edge.
  task automatic begin_phase(input cfg_t c, input int send_pct, input int recv_pct);
    wait_until_idle();
    program_settings(c);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Input driver. A transaction completes when in_valid is high and in_stall is low; the
  // predictor runs on exactly those. A held pixel keeps its payload until it is taken,
  // and the next one is offered only when the channel is free, with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_planes(in_data);
      end
      if (!in_valid || !in_stall) begin
        if (pixels_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data <= pixels_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Every result transaction is compared, field by field, with the oldest
  // expectation. The stall line toggles at random so that back-pressure lands on every
  // stage of the pipeline.
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (planes_due.size() == 0) begin
          $error("unexpected result: plane %0d value %0d last %0d",
                 out_data.plane, out_data.value, out_data.last);
          mismatch_count++;
        end else begin
          want = planes_due.pop_front();
          if (out_data.plane !== want.plane) begin
            $error("plane: expected %0d, got %0d", want.plane, out_data.plane);
            mismatch_count++;
          end
          if (out_data.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, out_data.value);
            mismatch_count++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_data.last);
            mismatch_count++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    mismatch_count = 0;
    cycle_count = 0;
    send_idle_pct = 8;
    recv_stall_pct = 47;
    // Register contents right after reset.
    active_cfg = settings(1, 1, 1, 0, 0, 16384, 0, 16384);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: position and gradient extremes with everything fitted.
    pixels_to_send.push_back(make_pixel(0, 0, 0, 0));
    pixels_to_send.push_back(make_pixel(4095, 4095, 32767, 32767));
    pixels_to_send.push_back(make_pixel(4095, 0, -32768, 32767));
    pixels_to_send.push_back(make_pixel(0, 4095, -32768, -32768));
    pixels_to_send.push_back(make_pixel(1234, 2345, -1, 1));

    // Center at opposite corners of its range, cosine pattern below -1.0, sine near 2.0
    // and the largest scale: rotation and scale saturate in both directions.
    begin_phase(settings(1, 1, 1, -65536, 65535, -32768, 32767, 65535), 8, 47);
    pixels_to_send.push_back(make_pixel(4095, 0, -32768, 32767));
    pixels_to_send.push_back(make_pixel(0, 4095, 32767, -32768));
    pixels_to_send.push_back(make_pixel(4095, 4095, -32768, -32768));
    pixels_to_send.push_back(make_pixel(0, 0, 32767, 32767));

    // The other extremes, with a scale of zero forcing the rotation value to zero.
    begin_phase(settings(1, 1, 1, 65535, -65536, 32767, -32768, 0), 8, 47);
    pixels_to_send.push_back(make_pixel(4095, 4095, 32767, -32768));
    pixels_to_send.push_back(make_pixel(0, 0, -1, -1));

    // A tiny cosine makes both rounded values land exactly on a half, first positive
    // then negative, which checks the direction of rounding.
    begin_phase(settings(1, 1, 1, 0, 0, 1, 0, 16384), 8, 47);
    pixels_to_send.push_back(make_pixel(1, 0, 512, 512));
    pixels_to_send.push_back(make_pixel(1, 0, -512, -512));

    // Each parameter fitted alone, then none at all, then rotation with scale.
    begin_phase(settings(1, 0, 0, 0, 0, 16384, 0, 16384), 8, 47);
    pixels_to_send.push_back(make_pixel(100, 200, -32768, 32767));
    pixels_to_send.push_back(make_pixel(4095, 0, 1, -1));
    begin_phase(settings(0, 1, 0, 800, -800, 11585, 11585, 20000), 8, 47);
    pixels_to_send.push_back(make_pixel(300, 400, 1000, -2000));
    begin_phase(settings(0, 0, 1, 800, -800, 11585, 11585, 20000), 8, 47);
    pixels_to_send.push_back(make_pixel(0, 4095, -32768, 32767));
    // With nothing to fit the pixels are taken but produce no results.
    begin_phase(settings(0, 0, 0, 800, -800, 11585, 11585, 20000), 8, 47);
    pixels_to_send.push_back(make_pixel(4095, 4095, 32767, 32767));
    pixels_to_send.push_back(make_pixel(0, 0, -32768, -32768));
    pixels_to_send.push_back(make_pixel(77, 99, 5, -5));
    begin_phase(settings(0, 1, 1, -1, 1, -11585, 11585, 16384), 8, 47);
    pixels_to_send.push_back(make_pixel(2048, 2048, -5, 7));

    // Random pixels under random settings. The idling pattern moves from a slow receiver
    // to a slow sender and finally to full speed on both sides. Every phase boundary
    // also makes the sender hold off until all owed results have arrived.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        begin_phase(random_settings(), 8, 47);
      end else if (ph < 4) begin
        begin_phase(random_settings(), 47, 8);
      end else begin
        begin_phase(random_settings(), 0, 0);
      end
      repeat (22) pixels_to_send.push_back(random_pixel());
    end

    wait_until_idle();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
